FILE: hdl/apf_pkg.sv
// Package for the amicable pair finder: sizes, status codes and shared types.
`default_nettype none
package apf_pkg;
  localparam int TABLE_DEPTH = 128;
  localparam int NUM_WIDTH   = 24;
  localparam int PART_W      = 27;
  localparam int SUM_W       = 31;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int DCNT_W      = $clog2(PART_W);
  localparam int ENTRY_W     = PART_W + NUM_WIDTH;

  localparam logic [1:0] ST_NONE   = 2'd0;
  localparam logic [1:0] ST_NEW    = 2'd1;
  localparam logic [1:0] ST_SKIP   = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic              start;
    logic [PART_W-1:0] n;
  } apf_sum_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] sum;
  } apf_sum_rsp_t;
endpackage
`default_nettype wire

FILE: hdl/apf_divsum.sv
// Proper divisor sum by trial division with a bit-serial restoring divider.
`default_nettype none
module apf_divsum import apf_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  apf_sum_req_t req_i,
  output apf_sum_rsp_t rsp_o
);
  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_CHK  = 4'b0010,
    D_DIV  = 4'b0100,
    D_ACC  = 4'b1000
  } dstate_e;

  dstate_e           state_q, state_d;
  logic [PART_W-1:0] n_q, d_q, rem_q, quo_q;
  logic [PART_W:0]   sq_q, t;
  logic [SUM_W-1:0]  total_q, sum_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              done_q, ge;

  assign t  = {rem_q, quo_q[PART_W-1]};
  assign ge = t >= {1'b0, d_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      D_IDLE: if (req_i.start) state_d = D_CHK;
      D_CHK:  state_d = (sq_q > {1'b0, n_q}) ? D_IDLE : D_DIV;
      D_DIV:  if (cnt_q == DCNT_W'(PART_W - 1)) state_d = D_ACC;
      D_ACC:  state_d = D_CHK;
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == D_CHK) && (sq_q > {1'b0, n_q});
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      D_IDLE: begin
        n_q     <= req_i.n;
        d_q     <= PART_W'(1);
        sq_q    <= (PART_W+1)'(1);
        total_q <= '0;
      end
      D_CHK: begin
        rem_q <= '0;
        quo_q <= n_q;
        cnt_q <= '0;
        sum_q <= total_q - SUM_W'(n_q);
      end
      D_DIV: begin
        rem_q <= ge ? PART_W'(t - {1'b0, d_q}) : t[PART_W-1:0];
        quo_q <= {quo_q[PART_W-2:0], ge};
        cnt_q <= cnt_q + DCNT_W'(1);
      end
      D_ACC: begin
        if (rem_q == '0) begin
          total_q <= total_q + SUM_W'(d_q) + ((quo_q != d_q) ? SUM_W'(quo_q) : '0);
        end
        d_q  <= d_q + PART_W'(1);
        sq_q <= sq_q + {d_q, 1'b1};
      end
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sum  = sum_q;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == D_IDLE) else $error("sum start while busy");
  a_done_after_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) == D_CHK) else $error("done without check");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == D_ACC |-> $past(state_q) == D_DIV) else $error("acc without divide");
`endif
endmodule
`default_nettype wire

FILE: hdl/amicable_pair_finder.sv
// Amicable pair finder top level: pair table, scan control and result register.
// Each pass scans the recorded table entries (read, then compare), then forms a divisor sum
// from trial divisors up to floor(sqrt(n)), each tested by the bit-serial divider.
// One item at a time; the next item is taken once the current result is registered.
// Reset (async, active low) clears the pair count and control; table contents stay undefined.
`default_nettype none
module amicable_pair_finder import apf_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire logic [NUM_WIDTH-1:0] candidate_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      logic [1:0]           status_o,
  output      logic [PART_W-1:0]    partner_o,
  output      logic [NUM_WIDTH-1:0] number_o
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_CMP  = 5'b00100,
    S_SUM  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e               state_q;
  logic                 phase_q, out_valid_q, acc, match, amic;
  logic [CNT_W-1:0]     count_q, idx_q;
  logic [NUM_WIDTH-1:0] cand_q, number_q;
  logic [PART_W-1:0]    s_q, v_q, partner_q;
  logic [1:0]           res_q, status_q;
  logic [ENTRY_W-1:0]   mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0]   rd_q;
  apf_sum_req_t         req;
  apf_sum_rsp_t         rsp;

  apf_divsum u_divsum (.clk_i, .rst_ni, .req_i(req), .rsp_o(rsp));

  assign in_stall_o = state_q != S_IDLE;
  assign acc   = in_valid_i && !in_stall_o;
  assign match = (rd_q[ENTRY_W-1:NUM_WIDTH] == v_q) ||
                 (PART_W'(rd_q[NUM_WIDTH-1:0]) == v_q);
  assign amic  = (rsp.sum == SUM_W'(cand_q)) && (s_q != PART_W'(cand_q));
  assign req.start = (state_q == S_RD) && (idx_q == count_q);
  assign req.n     = phase_q ? s_q : PART_W'(cand_q);

  always_ff @(posedge clk_i) begin
    rd_q <= mem[idx_q[IDX_W-1:0]];
    if (state_q == S_SUM && rsp.done && phase_q && amic &&
        count_q < CNT_W'(TABLE_DEPTH)) begin
      mem[count_q[IDX_W-1:0]] <= {s_q, cand_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (!out_stall_i && state_q != S_DONE) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (acc) begin
          cand_q  <= candidate_i;
          v_q     <= PART_W'(candidate_i);
          s_q     <= '0;
          phase_q <= 1'b0;
          idx_q   <= '0;
          state_q <= S_RD;
        end
        S_RD: state_q <= (idx_q == count_q) ? S_SUM : S_CMP;
        S_CMP: begin
          if (match) begin
            res_q   <= ST_SKIP;
            state_q <= S_DONE;
          end else begin
            idx_q   <= idx_q + CNT_W'(1);
            state_q <= S_RD;
          end
        end
        S_SUM: if (rsp.done) begin
          if (!phase_q) begin
            s_q     <= rsp.sum[PART_W-1:0];
            v_q     <= rsp.sum[PART_W-1:0];
            phase_q <= 1'b1;
            idx_q   <= '0;
            state_q <= S_RD;
          end else begin
            if (!amic) begin
              res_q <= ST_NONE;
            end else if (count_q >= CNT_W'(TABLE_DEPTH)) begin
              res_q <= ST_FULL;
            end else begin
              res_q   <= ST_NEW;
              count_q <= count_q + CNT_W'(1);
            end
            state_q <= S_DONE;
          end
        end
        S_DONE: if (!out_valid_q || !out_stall_i) begin
          out_valid_q <= 1'b1;
          status_q    <= res_q;
          partner_q   <= s_q;
          number_q    <= cand_q;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign partner_o   = partner_q;
  assign number_o    = number_q;

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH)) else $error("pair count overflow");
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> state_q == S_RD) else $error("accept did not start scan");
  a_done_in_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> state_q == S_SUM) else $error("sum done outside sum state");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> res_q == ST_NEW) else $error("count moved without pair");
`endif
endmodule
`default_nettype wire
